// ----- sv/bqae_pkg.sv -----
package bqae_pkg;

    localparam int TAPS_DEFAULT = 8;

    // Field and datapath widths.
    localparam int X_W    = 16;
    localparam int W_W    = 24;
    localparam int PROD_W = 41;
    localparam int ACC_W  = 48;
    localparam int E_W    = 18;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 3;
    localparam int DIV_W  = 32;
    localparam int DEN_W  = 22;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_STEP_INIT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_STEP_RATIO = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP_PER   = 3'd2;
    localparam logic [IDX_W-1:0] REG_VAR_RATIO  = 3'd3;
    localparam logic [IDX_W-1:0] REG_VAR_PER    = 3'd4;
    localparam logic [IDX_W-1:0] REG_LEVEL      = 3'd5;
    localparam logic [IDX_W-1:0] REG_VAR_INIT   = 3'd6;
    localparam logic [IDX_W-1:0] REG_FIRST_TAP  = 3'd7;

    localparam logic signed [W_W-1:0] FIRST_TAP_RST = 24'sd1048576;

    // Control of one cell of the tap chain.
    typedef struct packed {
        logic shift;
        logic prod;
        logic sum;
        logic corr;
        logic upd;
    } t_cell_ctrl;

    // Logistic sigmoid samples at steps of 0.5, Q0.16.
    function automatic logic [15:0] sig_point(input logic [4:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:  v = 16'd32768;
            5'd1:  v = 16'd40793;
            5'd2:  v = 16'd47911;
            5'd3:  v = 16'd53581;
            5'd4:  v = 16'd57724;
            5'd5:  v = 16'd60565;
            5'd6:  v = 16'd62428;
            5'd7:  v = 16'd63615;
            5'd8:  v = 16'd64357;
            5'd9:  v = 16'd64816;
            5'd10: v = 16'd65097;
            5'd11: v = 16'd65269;
            5'd12: v = 16'd65374;
            5'd13: v = 16'd65438;
            5'd14: v = 16'd65476;
            5'd15: v = 16'd65500;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

    // Sigmoid of a Q8 magnitude with sign, interpolated, Q0.16.
    function automatic logic [16:0] sigmoid(input logic [DIV_W-1:0] mag, input logic neg);
        logic [11:0] a;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [19:0] fprod;
        logic [16:0] s;
        a = (mag > 32'd2048) ? 12'd2048 : mag[11:0];
        lo = sig_point(a[11:7]);
        hi = sig_point(a[11:7] + 5'd1);
        fprod = 20'(hi - lo) * 20'(a[6:0]);
        if (a[11]) begin
            s = 17'(sig_point(5'd16));
        end else begin
            s = 17'(lo) + 17'(fprod[19:7]);
        end
        return neg ? (17'd65536 - s) : s;
    endfunction

endpackage

// ----- sv/blind_qpsk_adaptive_equalizer.sv -----
// Blind QPSK equalizer with a TAPS-long complex FIR and soft-decision LMS
// adaptation. A request is accepted only in idle, and the next one is not
// taken until the adaptation for the last is done: a product step, the partial
// sum rippling down the tap chain, and three passes of a shared 32-step divider
// (one per axis for the sigmoid argument, one for step/variance) that hold the
// sequencer, with rounding, sigmoid lookup and weight update steps around them.
// The filter output is registered as soon as it is formed, so the adaptation
// goes on while the result waits; only a result still waiting when the next
// output is formed holds the sequencer, and adds the cycles it waits.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce it.
module blind_qpsk_adaptive_equalizer #(
    parameter int TAPS = bqae_pkg::TAPS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [bqae_pkg::X_W-1:0]    i_sample_re,
    input  logic signed [bqae_pkg::X_W-1:0]    i_sample_im,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [bqae_pkg::X_W-1:0]    o_out_re,
    output logic signed [bqae_pkg::X_W-1:0]    o_out_im,
    input  logic                               i_cfg_we,
    input  logic [bqae_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [bqae_pkg::CFG_W-1:0]         i_cfg_data
);
    import bqae_pkg::*;

    localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROD  = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_ROUND = 4'd3;
    localparam logic [3:0] S_NUM   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SOFT  = 4'd6;
    localparam logic [3:0] S_SCALE = 4'd7;
    localparam logic [3:0] S_GDIV  = 4'd8;
    localparam logic [3:0] S_GWAIT = 4'd9;
    localparam logic [3:0] S_CORR  = 4'd10;
    localparam logic [3:0] S_UPD   = 4'd11;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_axis;

    logic [15:0] r_step_ratio, r_step_per, r_var_ratio, r_var_per;
    logic [14:0] r_level;
    logic [15:0] r_step_now, r_var_now, r_step_cnt, r_var_cnt;
    logic        r_step_hit, r_var_hit;

    logic signed [X_W-1:0] r_y_re, r_y_im, r_out_re, r_out_im;
    logic                  r_out_valid;
    logic [DIV_W-1:0]      r_num;
    logic [DEN_W-1:0]      r_den;
    logic                  r_div_start;
    logic [16:0]           r_sig;
    logic signed [E_W-1:0] r_err_re, r_err_im;
    logic [W_W-1:0]        r_gain;

    logic             accept;
    logic             cfg_idle;
    logic [15:0]      veff;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    t_cell_ctrl       ctrl;

    logic signed [X_W-1:0]   x_re [TAPS+1];
    logic signed [X_W-1:0]   x_im [TAPS+1];
    logic signed [ACC_W-1:0] ps_re [TAPS+1];
    logic signed [ACC_W-1:0] ps_im [TAPS+1];

    logic signed [ACC_W-1:0] rnd_re, rnd_im;
    logic signed [X_W-1:0]   y_re, y_im;
    logic signed [X_W-1:0]   y_sel;
    logic [16:0]             y_mag;
    logic [31:0]             lm_prod;
    logic signed [E_W-1:0]   dsig;
    logic signed [33:0]      ld_prod;
    logic signed [E_W-1:0]   soft_sym;
    logic signed [E_W-1:0]   err;
    logic [31:0]             sc_step, sc_var;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_idle   = i_cfg_we;
    assign veff       = (r_var_now == 16'd0) ? 16'd1 : r_var_now;

    // Cell controls follow the sequencer state.
    always_comb begin
        ctrl.shift = accept;
        ctrl.prod  = (r_state == S_PROD);
        ctrl.sum   = (r_state == S_SUM);
        ctrl.corr  = (r_state == S_CORR);
        ctrl.upd   = (r_state == S_UPD);
    end

    // Row of tap cells: samples move right on accept, partial sums ripple right.
    assign x_re[0]  = i_sample_re;
    assign x_im[0]  = i_sample_im;
    assign ps_re[0] = '0;
    assign ps_im[0] = '0;

    for (genvar i = 0; i < TAPS; i++) begin : g_cell
        bqae_cell #(
            .W_RE_RST((i == 0) ? FIRST_TAP_RST : '0)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl),
            .i_x_re    (x_re[i]),
            .i_x_im    (x_im[i]),
            .o_x_re    (x_re[i+1]),
            .o_x_im    (x_im[i+1]),
            .i_psum_re (ps_re[i]),
            .i_psum_im (ps_im[i]),
            .o_psum_re (ps_re[i+1]),
            .o_psum_im (ps_im[i+1]),
            .i_err_re  (r_err_re),
            .i_err_im  (r_err_im),
            .i_gain    (r_gain),
            .i_w_load  ((i == 0) && cfg_idle && (i_cfg_index == REG_FIRST_TAP)),
            .i_w_init  ($signed(i_cfg_data[W_W-1:0]))
        );
    end

    // Shared divider for the sigmoid argument and the gain.
    bqae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Filter output: round half up from Q14.34 and saturate to Q2.14.
    assign rnd_re = (ps_re[TAPS] + ACC_W'(524288)) >>> 20;
    assign rnd_im = (ps_im[TAPS] + ACC_W'(524288)) >>> 20;

    always_comb begin
        if (rnd_re > ACC_W'(32767)) begin
            y_re = 16'sh7FFF;
        end else if (rnd_re < -ACC_W'(32768)) begin
            y_re = 16'sh8000;
        end else begin
            y_re = rnd_re[X_W-1:0];
        end
        if (rnd_im > ACC_W'(32767)) begin
            y_im = 16'sh7FFF;
        end else if (rnd_im < -ACC_W'(32768)) begin
            y_im = 16'sh8000;
        end else begin
            y_im = rnd_im[X_W-1:0];
        end
    end

    // Soft decision on the current axis.
    assign y_sel    = r_axis ? r_y_im : r_y_re;
    assign y_mag    = y_sel[X_W-1] ? 17'(-18'(y_sel)) : 17'(y_sel);
    assign lm_prod  = 32'(r_level) * 32'(y_mag);
    assign dsig     = $signed({r_sig, 1'b0}) - 18'sd65536;
    assign ld_prod  = $signed({19'd0, r_level}) * 34'(dsig);
    assign soft_sym = E_W'((ld_prod + 34'sd32768) >>> 16);
    assign err      = soft_sym - E_W'(y_sel);

    // Step and variance rescaling by their Q1.15 ratios.
    assign sc_step = (32'(r_step_now) * 32'(r_step_ratio)) >> 15;
    assign sc_var  = (32'(r_var_now) * 32'(r_var_ratio)) >> 15;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) begin n_state = S_PROD; end
            S_PROD:  n_state = S_SUM;
            S_SUM:   if (r_cnt == CNT_W'(TAPS - 1)) begin n_state = S_ROUND; end
            S_ROUND: if (!r_out_valid || !i_out_stall) begin n_state = S_NUM; end
            S_NUM:   n_state = S_DIV;
            S_DIV:   if (div_done) begin n_state = S_SOFT; end
            S_SOFT:  n_state = r_axis ? S_SCALE : S_NUM;
            S_SCALE: n_state = S_GDIV;
            S_GDIV:  n_state = S_GWAIT;
            S_GWAIT: if (div_done) begin n_state = S_CORR; end
            S_CORR:  n_state = S_UPD;
            S_UPD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and adaptation registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_axis       <= 1'b0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_step_ratio <= 16'd32768;
            r_step_per   <= 16'd4000;
            r_var_ratio  <= 16'd32768;
            r_var_per    <= 16'd4000;
            r_level      <= 15'd16384;
            r_step_now   <= 16'd590;
            r_var_now    <= 16'd2294;
            r_step_cnt   <= '0;
            r_var_cnt    <= '0;
            r_step_hit   <= 1'b0;
            r_var_hit    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= 1'b0;

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_idle) begin
                unique case (i_cfg_index)
                    REG_STEP_INIT:  r_step_now   <= i_cfg_data[15:0];
                    REG_STEP_RATIO: r_step_ratio <= i_cfg_data[15:0];
                    REG_STEP_PER:   r_step_per   <= i_cfg_data[15:0];
                    REG_VAR_RATIO:  r_var_ratio  <= i_cfg_data[15:0];
                    REG_VAR_PER:    r_var_per    <= i_cfg_data[15:0];
                    REG_LEVEL:      r_level      <= i_cfg_data[14:0];
                    REG_VAR_INIT:   r_var_now    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // Period counters: a match clears the count and marks a rescale.
            if (accept) begin
                r_step_hit <= ((r_step_cnt + 16'd1) == r_step_per);
                r_var_hit  <= ((r_var_cnt + 16'd1) == r_var_per);
                r_step_cnt <= ((r_step_cnt + 16'd1) == r_step_per) ? 16'd0
                                                                   : r_step_cnt + 16'd1;
                r_var_cnt  <= ((r_var_cnt + 16'd1) == r_var_per) ? 16'd0
                                                                 : r_var_cnt + 16'd1;
            end

            if (r_state == S_PROD) begin
                r_cnt <= '0;
            end else if (r_state == S_SUM) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if ((r_state == S_ROUND) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
                r_axis      <= 1'b0;
            end

            if (r_state == S_NUM) begin
                r_div_start <= 1'b1;
            end
            if (r_state == S_SOFT) begin
                r_axis <= ~r_axis;
            end

            if (r_state == S_SCALE) begin
                if (r_step_hit) begin
                    r_step_now <= (sc_step > 32'd65535) ? 16'd65535 : sc_step[15:0];
                end
                if (r_var_hit) begin
                    r_var_now <= (sc_var > 32'd65535) ? 16'd65535 : sc_var[15:0];
                end
            end
            if (r_state == S_GDIV) begin
                r_div_start <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_ROUND) && (!r_out_valid || !i_out_stall)) begin
            r_out_re <= y_re;
            r_out_im <= y_im;
            r_y_re   <= y_re;
            r_y_im   <= y_im;
        end
        if (r_state == S_NUM) begin
            r_num <= {lm_prod[30:0], 1'b0};
            r_den <= {veff, 6'd0};
        end
        if ((r_state == S_DIV) && div_done) begin
            r_sig <= sigmoid(div_quot, y_sel[X_W-1]);
        end
        if (r_state == S_SOFT) begin
            if (r_axis) begin
                r_err_im <= err;
            end else begin
                r_err_re <= err;
            end
        end
        if (r_state == S_GDIV) begin
            r_num <= {2'd0, r_step_now, 14'd0};
            r_den <= {6'd0, veff};
        end
        if ((r_state == S_GWAIT) && div_done) begin
            r_gain <= (div_quot > 32'hFFFFFF) ? 24'hFFFFFF : div_quot[W_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;

endmodule

// ----- sv/bqae_div.sv -----
module bqae_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bqae_pkg::DIV_W-1:0]   i_num,
    input  logic [bqae_pkg::DEN_W-1:0]   i_den,
    output logic                         o_done,
    output logic [bqae_pkg::DIV_W-1:0]   o_quot
);
    import bqae_pkg::*;

    logic             r_busy;
    logic [4:0]       r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_done;
    logic [DEN_W:0]   n_shift;
    logic             n_fit;

    // One restoring step: bring down the next numerator bit and try the subtract.
    assign n_shift = {r_rem, r_q[DIV_W-1]};
    assign n_fit   = (n_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in as numerator bits shift out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q <= {r_q[DIV_W-2:0], n_fit};
            if (n_fit) begin
                r_rem <= DEN_W'(n_shift - {1'b0, r_den});
            end else begin
                r_rem <= n_shift[DEN_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- sv/bqae_cell.sv -----
module bqae_cell #(
    parameter logic signed [bqae_pkg::W_W-1:0] W_RE_RST = '0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bqae_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [bqae_pkg::X_W-1:0]     i_x_re,
    input  logic signed [bqae_pkg::X_W-1:0]     i_x_im,
    output logic signed [bqae_pkg::X_W-1:0]     o_x_re,
    output logic signed [bqae_pkg::X_W-1:0]     o_x_im,
    input  logic signed [bqae_pkg::ACC_W-1:0]   i_psum_re,
    input  logic signed [bqae_pkg::ACC_W-1:0]   i_psum_im,
    output logic signed [bqae_pkg::ACC_W-1:0]   o_psum_re,
    output logic signed [bqae_pkg::ACC_W-1:0]   o_psum_im,
    input  logic signed [bqae_pkg::E_W-1:0]     i_err_re,
    input  logic signed [bqae_pkg::E_W-1:0]     i_err_im,
    input  logic [bqae_pkg::W_W-1:0]            i_gain,
    input  logic                                i_w_load,
    input  logic signed [bqae_pkg::W_W-1:0]     i_w_init
);
    import bqae_pkg::*;

    logic signed [X_W-1:0]    r_x_re, r_x_im;
    logic signed [W_W-1:0]    r_w_re, r_w_im;
    logic signed [PROD_W-1:0] r_prod_re, r_prod_im;
    logic signed [ACC_W-1:0]  r_psum_re, r_psum_im;

    logic signed [39:0] m_rr, m_ii, m_ri, m_ir;
    logic signed [33:0] c_rr, c_ii, c_ir, c_ri;
    logic signed [34:0] c_re, c_im;
    logic signed [24:0] g_s;
    logic signed [59:0] u_re, u_im;
    logic signed [35:0] d_re, d_im;
    logic signed [36:0] s_re, s_im;
    logic signed [W_W-1:0] n_w_re, n_w_im;

    // Filter products: x times w.
    assign m_rr = r_x_re * r_w_re;
    assign m_ii = r_x_im * r_w_im;
    assign m_ri = r_x_re * r_w_im;
    assign m_ir = r_x_im * r_w_re;

    // Correlation of the error with conj(x).
    assign c_rr = i_err_re * r_x_re;
    assign c_ii = i_err_im * r_x_im;
    assign c_ir = i_err_im * r_x_re;
    assign c_ri = i_err_re * r_x_im;
    assign c_re = 35'(c_rr) + 35'(c_ii);
    assign c_im = 35'(c_ir) - 35'(c_ri);

    // Scaled update, rounded from Q44 to Q20, then saturated weight.
    assign g_s  = $signed({1'b0, i_gain});
    assign u_re = g_s * $signed(r_prod_re[34:0]);
    assign u_im = g_s * $signed(r_prod_im[34:0]);
    assign d_re = 36'((u_re + 60'sd8388608) >>> 24);
    assign d_im = 36'((u_im + 60'sd8388608) >>> 24);
    assign s_re = 37'(r_w_re) + 37'(d_re);
    assign s_im = 37'(r_w_im) + 37'(d_im);

    always_comb begin
        if (s_re > 37'sd8388607) begin
            n_w_re = 24'sh7FFFFF;
        end else if (s_re < -37'sd8388608) begin
            n_w_re = 24'sh800000;
        end else begin
            n_w_re = s_re[W_W-1:0];
        end
        if (s_im > 37'sd8388607) begin
            n_w_im = 24'sh7FFFFF;
        end else if (s_im < -37'sd8388608) begin
            n_w_im = 24'sh800000;
        end else begin
            n_w_im = s_im[W_W-1:0];
        end
    end

    // Delay tap and weights.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_re <= '0;
            r_x_im <= '0;
            r_w_re <= W_RE_RST;
            r_w_im <= '0;
        end else begin
            if (i_ctrl.shift) begin
                r_x_re <= i_x_re;
                r_x_im <= i_x_im;
            end
            if (i_w_load) begin
                r_w_re <= i_w_init;
            end else if (i_ctrl.upd) begin
                r_w_re <= n_w_re;
                r_w_im <= n_w_im;
            end
        end
    end

    // Product register and the partial sum passed down the chain.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.prod) begin
            r_prod_re <= PROD_W'(m_rr) - PROD_W'(m_ii);
            r_prod_im <= PROD_W'(m_ri) + PROD_W'(m_ir);
        end else if (i_ctrl.corr) begin
            r_prod_re <= PROD_W'(c_re);
            r_prod_im <= PROD_W'(c_im);
        end
        if (i_ctrl.sum) begin
            r_psum_re <= i_psum_re + ACC_W'(r_prod_re);
            r_psum_im <= i_psum_im + ACC_W'(r_prod_im);
        end
    end

    assign o_x_re    = r_x_re;
    assign o_x_im    = r_x_im;
    assign o_psum_re = r_psum_re;
    assign o_psum_im = r_psum_im;

endmodule
